@@ sv/spectral_flux_onset_locator_macros.svh @@
// ----------------------------------------------------------------------------
// spectral_flux_onset_locator_macros
// Assertion shorthands shared by the onset locator. Each expects clk and
// rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SPECTRAL_FLUX_ONSET_LOCATOR_MACROS_SVH
`define SPECTRAL_FLUX_ONSET_LOCATOR_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SFOL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define SFOL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/sfol_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfol_pkg
// Types, register indexes and helpers of the spectral-flux onset locator.
// ----------------------------------------------------------------------------
package sfol_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int SUM_W       = 22;
  localparam int ORIGIN_W    = 6;
  localparam int THR_W       = 8;
  localparam int MW_W        = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int PREV10_W    = SUM_W + 4;
  localparam int RHS_W       = PREV10_W + THR_W;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_SCALE   = 2'd2;

  localparam logic [THR_W-1:0] THRESHOLD_RST    = 8'd128;
  localparam logic [MW_W-1:0]  MATRIX_WIDTH_RST = 7'd8;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] bin_value;
    logic                   last_bin;
  } sfol_in_t;

  typedef struct packed {
    logic                fired;
    logic [ORIGIN_W-1:0] origin_column;
    logic [ORIGIN_W-1:0] origin_row;
    logic [SUM_W-1:0]    energy_rise;
  } sfol_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MULT,
    ST_DIV,
    ST_DONE
  } sfol_state_t;

  typedef struct packed {
    logic accept;
    logic update;
    logic mult;
    logic div_step;
    logic finish;
  } sfol_cmd_t;

  typedef struct packed {
    logic last_item;
  } sfol_status_t;

  // x / 100 by reciprocal: 83887 / 2^23 is exact for every 16-bit x
  function automatic logic [SAMPLE_BITS-1:0] div100(input logic [SAMPLE_BITS-1:0] x);
    logic [32:0] prod;
    prod = 33'(x) * 33'(83887);
    return SAMPLE_BITS'(prod[32:23]);
  endfunction

endpackage

@@ sv/sfol_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfol_ram
// Generic single-port RAM, write-enable, registered read.
// ----------------------------------------------------------------------------
module sfol_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/sfol_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfol_ctrl
// Sequencer: bin read/update, then for a closing bin the threshold multiply,
// the bit-serial grid division and the result load.
// ----------------------------------------------------------------------------
module sfol_ctrl
  import sfol_pkg::*;
#(
  parameter int MAX_BINS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  output sfol_cmd_t    cmd,
  input  sfol_status_t st
);

  localparam int BIN_W  = $clog2(MAX_BINS);
  localparam int STEP_W = $clog2(BIN_W + 1);

  sfol_state_t       state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    in_stall      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = st.last_item ? ST_MULT : ST_IDLE;
      end
      ST_MULT: begin
        cmd.mult  = 1'b1;
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == STEP_W'(BIN_W - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold the finished frame until the result slot is free
        if (!out_valid_r || !out_stall) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

@@ sv/sfol_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfol_dp
// Datapath: previous-frame memory, rise sum and best bin, threshold
// product, restoring divider for the grid split, result register and
// configuration registers.
// ----------------------------------------------------------------------------
module sfol_dp
  import sfol_pkg::*;
#(
  parameter int MAX_BINS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sfol_cmd_t             cmd,
  output sfol_status_t          st,
  input  sfol_in_t              in_data,
  output sfol_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int BIN_W = $clog2(MAX_BINS);
  localparam int CNT_W = $clog2(MAX_BINS + 1);

  // configuration
  logic [THR_W-1:0] thr_r, thr_nxt;
  logic [MW_W-1:0]  mw_r, mw_nxt;
  logic             scale_r, scale_nxt;

  // frame state
  logic [CNT_W-1:0]       bin_cnt_r, bin_cnt_nxt;
  logic [CNT_W-1:0]       fill_r, fill_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [SUM_W-1:0]       prev_sum_r, prev_sum_nxt;
  logic [SAMPLE_BITS-1:0] best_rise_r, best_rise_nxt;
  logic [BIN_W-1:0]       best_bin_r, best_bin_nxt;

  // per-request payload
  logic [SAMPLE_BITS-1:0] raw_r, raw_nxt;
  logic [SAMPLE_BITS-1:0] cur_r, cur_nxt;
  logic                   last_r, last_nxt;
  logic                   in_range_r, in_range_nxt;

  // frame close
  logic [RHS_W-1:0] rhs_r, rhs_nxt;
  logic [BIN_W-1:0] quo_r, quo_nxt;
  logic [MW_W-1:0]  rem_r, rem_nxt;
  sfol_out_t        out_r, out_nxt;

  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic [SAMPLE_BITS-1:0] prev_val;
  logic [SAMPLE_BITS-1:0] rise;
  logic [SUM_W:0]         sum_ext;
  logic                   ram_we;
  logic [PREV10_W-1:0]    prev10;
  logic [MW_W-1:0]        w_eff;
  logic [MW_W:0]          trial;
  logic [MW_W:0]          trial_diff;
  logic                   trial_ge;
  logic [BIN_W:0]         quo_shift;
  logic                   fire;

  assign ram_we = cmd.update && in_range_r;

  sfol_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_BINS)
  ) u_prev_frame (
    .clk   (clk),
    .we    (ram_we),
    .addr  (bin_cnt_r[BIN_W-1:0]),
    .wdata (raw_r),
    .rdata (ram_rdata)
  );

  // entries are always written in bin order, so those below the fill
  // mark are the written ones; the rest read as the reset zero
  assign prev_val = (bin_cnt_r < fill_r) ? ram_rdata : '0;
  assign rise     = cur_r - prev_val;
  assign sum_ext  = {1'b0, sum_r} + (SUM_W + 1)'(rise);

  assign prev10 = {1'b0, prev_sum_r, 3'b000} + {3'b000, prev_sum_r, 1'b0};

  assign w_eff      = (mw_r == '0) ? MW_W'(1) : mw_r;
  assign trial      = {rem_r, quo_r[BIN_W-1]};
  assign trial_ge   = trial >= {1'b0, w_eff};
  assign trial_diff = trial - {1'b0, w_eff};
  assign quo_shift  = {quo_r, trial_ge};

  assign fire = RHS_W'({sum_r, 8'b0}) > rhs_r;

  always_comb begin
    thr_nxt       = thr_r;
    mw_nxt        = mw_r;
    scale_nxt     = scale_r;
    bin_cnt_nxt   = bin_cnt_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    prev_sum_nxt  = prev_sum_r;
    best_rise_nxt = best_rise_r;
    best_bin_nxt  = best_bin_r;
    raw_nxt       = raw_r;
    cur_nxt       = cur_r;
    last_nxt      = last_r;
    in_range_nxt  = in_range_r;
    rhs_nxt       = rhs_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    out_nxt       = out_r;

    if (cmd.accept) begin
      raw_nxt      = in_data.bin_value;
      last_nxt     = in_data.last_bin;
      cur_nxt      = (in_data.last_bin && scale_r) ? div100(in_data.bin_value)
                                                   : in_data.bin_value;
      in_range_nxt = bin_cnt_r < CNT_W'(MAX_BINS);
    end

    if (cmd.update && in_range_r) begin
      if (cur_r > prev_val) begin
        if (rise > best_rise_r) begin
          best_rise_nxt = rise;
          best_bin_nxt  = bin_cnt_r[BIN_W-1:0];
        end
        sum_nxt = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
      end
      bin_cnt_nxt = bin_cnt_r + CNT_W'(1);
      if (bin_cnt_r == fill_r) begin
        fill_nxt = fill_r + CNT_W'(1);
      end
    end

    if (cmd.mult) begin
      rhs_nxt = RHS_W'(prev10) * RHS_W'(thr_r);
      quo_nxt = best_bin_r;
      rem_nxt = '0;
    end

    // one quotient bit per step
    if (cmd.div_step) begin
      rem_nxt = trial_ge ? trial_diff[MW_W-1:0] : trial[MW_W-1:0];
      quo_nxt = quo_shift[BIN_W-1:0];
    end

    if (cmd.finish) begin
      out_nxt.fired         = fire;
      out_nxt.origin_column = fire ? ORIGIN_W'(rem_r) : '0;
      out_nxt.origin_row    = fire ? ORIGIN_W'(quo_r) : '0;
      out_nxt.energy_rise   = sum_r;
      prev_sum_nxt          = sum_r;
      bin_cnt_nxt           = '0;
      sum_nxt               = '0;
      best_rise_nxt         = '0;
      best_bin_nxt          = '0;
    end

    if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD:    thr_nxt   = cfg_data[THR_W-1:0];
        CFG_MATRIX_WIDTH: mw_nxt    = cfg_data[MW_W-1:0];
        CFG_LAST_SCALE:   scale_nxt = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THRESHOLD_RST;
      mw_r        <= MATRIX_WIDTH_RST;
      scale_r     <= 1'b1;
      bin_cnt_r   <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      prev_sum_r  <= '0;
      best_rise_r <= '0;
      best_bin_r  <= '0;
    end else begin
      thr_r       <= thr_nxt;
      mw_r        <= mw_nxt;
      scale_r     <= scale_nxt;
      bin_cnt_r   <= bin_cnt_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      prev_sum_r  <= prev_sum_nxt;
      best_rise_r <= best_rise_nxt;
      best_bin_r  <= best_bin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    raw_r      <= raw_nxt;
    cur_r      <= cur_nxt;
    last_r     <= last_nxt;
    in_range_r <= in_range_nxt;
    rhs_r      <= rhs_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    out_r      <= out_nxt;
  end

  assign st.last_item = last_r;
  assign out_data     = out_r;

endmodule

@@ sv/spectral_flux_onset_locator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectral_flux_onset_locator
// Spectral-flux onset detector with grid origin of the strongest rising bin.
// ----------------------------------------------------------------------------
// Bins are taken one request at a time. The accept step reads the same
// bin of the previous frame from the single-port frame memory; the update
// step differences, accumulates and writes the raw value back. The bin
// flagged last then runs the threshold multiply, one division step per
// quotient bit of the row/column division, and the load of the result
// register, which waits while the previous result has not yet been taken.
// A result may wait on the output while the next frame streams in.
// The frame memory needs no clearing pass after reset; unwritten bins
// read as zero. Configuration writes are always ready and are meant for
// idle periods.
// ----------------------------------------------------------------------------
`include "spectral_flux_onset_locator_macros.svh"

module spectral_flux_onset_locator
  import sfol_pkg::*;
#(
  parameter int MAX_BINS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sfol_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sfol_out_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  sfol_cmd_t    cmd;
  sfol_status_t st;

  assign cfg_ready = 1'b1;

  sfol_ctrl #(
    .MAX_BINS (MAX_BINS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .st        (st)
  );

  sfol_dp #(
    .MAX_BINS (MAX_BINS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // a request always needs the update cycle behind it
  `SFOL_ASSERT_NEXT(a_accept_then_busy, in_valid && !in_stall, in_stall, "request accepted in back-to-back cycles")

  // firing needs a non-zero rise sum
  `SFOL_ASSERT_SAME(a_fire_has_rise, out_valid && out_data.fired, out_data.energy_rise != '0, "fired with zero rise")

  // no origin unless fired
  `SFOL_ASSERT_SAME(a_quiet_origin, out_valid && !out_data.fired, out_data.origin_column == '0 && out_data.origin_row == '0, "origin set without fire")

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the spectral-flux onset locator.
// ----------------------------------------------------------------------------
// Frames of bin magnitudes are queued by the stimulus process and driven
// one request per handshake. Each accepted request updates a local model of
// the previous-frame store and rise tracking. Each closed frame queues the
// report it should produce, and the monitor compares every report it takes
// against the oldest one queued. Register settings change between phases,
// only once the block has gone quiet.
// ----------------------------------------------------------------------------
module tb;
  import sfol_pkg::*;

  localparam int BIN_SLOTS     = 64;
  localparam int SETTLE_CYCLES = 24;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int HOLD_CYCLES   = 500;
  localparam int PHASES        = 8;
  localparam int PHASE_BINS    = 200;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  sfol_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  sfol_out_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  spectral_flux_onset_locator #(.MAX_BINS(BIN_SLOTS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // model of the register file
  logic [THR_W-1:0] thr        = THRESHOLD_RST;
  logic [MW_W-1:0]  grid_cols  = MATRIX_WIDTH_RST;
  logic             scale_last = 1'b1;

  // model of the frame state
  logic [SAMPLE_BITS-1:0] prev_mag [BIN_SLOTS];
  int                     bin_idx   = 0;
  logic [SUM_W-1:0]       rise_acc  = '0;
  logic [SAMPLE_BITS-1:0] peak_rise = '0;
  logic [ORIGIN_W-1:0]    peak_bin  = '0;
  logic [SUM_W-1:0]       last_rise = '0;

  sfol_in_t  bins_to_send [$];
  sfol_out_t onsets_due [$];
  int        bins_pushed = 0;
  int        bins_taken  = 0;
  int        bad_count   = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        hold_left  = 0;
  int        holds_done = 0;
  int        cycle_count = 0;

  initial begin
    foreach (prev_mag[i]) prev_mag[i] = '0;
  end

  task automatic track_bin(input sfol_in_t req);
    logic [SAMPLE_BITS-1:0] cur;
    logic [SAMPLE_BITS-1:0] gain;
    logic [SUM_W:0]         total;
    logic [63:0]            lhs;
    logic [63:0]            rhs;
    int unsigned            cols;
    sfol_out_t              rep;
    cur = req.bin_value;
    if (bin_idx < BIN_SLOTS) begin
      if (req.last_bin && scale_last) cur = req.bin_value / 16'd100;
      if (cur > prev_mag[bin_idx]) begin
        gain  = cur - prev_mag[bin_idx];
        total = {1'b0, rise_acc} + (SUM_W+1)'(gain);
        // strict compare: earliest bin keeps a tie
        if (gain > peak_rise) begin
          peak_rise = gain;
          peak_bin  = ORIGIN_W'(bin_idx);
        end
        rise_acc = (total > {1'b0, SUM_MAX}) ? SUM_MAX : total[SUM_W-1:0];
      end
      prev_mag[bin_idx] = req.bin_value;  // raw value kept, even when scaled
      bin_idx++;
    end
    if (req.last_bin) begin
      lhs  = 64'(rise_acc) * 64'd256;
      rhs  = 64'(last_rise) * 64'd10 * 64'(thr);
      cols = (grid_cols == '0) ? 1 : int'(grid_cols);
      rep.fired         = lhs > rhs;
      rep.origin_column = rep.fired ? ORIGIN_W'(int'(peak_bin) % cols) : '0;
      rep.origin_row    = rep.fired ? ORIGIN_W'(int'(peak_bin) / cols) : '0;
      rep.energy_rise   = rise_acc;
      onsets_due.insert(onsets_due.size(), rep);
      last_rise = rise_acc;
      bin_idx   = 0;
      rise_acc  = '0;
      peak_rise = '0;
      peak_bin  = '0;
    end
  endtask

  // driver: a stalled request is held unchanged
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_bin(in_data);
        bins_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (bins_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= bins_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, started twice mid-stream so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && bins_taken >= 300 + holds_done * 800) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    sfol_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (onsets_due.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("unexpected report: fired=%0d col=%0d row=%0d rise=%0d",
                     out_data.fired, out_data.origin_column, out_data.origin_row,
                     out_data.energy_rise);
        end else begin
          want = onsets_due.pop_front();
          if (out_data.fired !== want.fired ||
              out_data.origin_column !== want.origin_column ||
              out_data.origin_row !== want.origin_row ||
              out_data.energy_rise !== want.energy_rise) begin
            bad_count++;
            if (bad_count <= 10)
              $display({"report mismatch: expected fired=%0d col=%0d row=%0d rise=%0d,",
                        " got fired=%0d col=%0d row=%0d rise=%0d"},
                       want.fired, want.origin_column, want.origin_row,
                       want.energy_rise, out_data.fired, out_data.origin_column,
                       out_data.origin_row, out_data.energy_rise);
          end
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_bin(input logic [SAMPLE_BITS-1:0] value, input logic last);
    sfol_in_t req;
    req.bin_value = value;
    req.last_bin  = last;
    bins_to_send.insert(bins_to_send.size(), req);
    bins_pushed++;
  endtask

  // short and mid-length frames mostly; now and then a single bin or one
  // that can run past the store depth
  task automatic queue_frame();
    int          len;
    int          pick;
    int unsigned amp;
    logic [SAMPLE_BITS-1:0] v;
    pick = $urandom_range(99);
    if (pick < 5) len = $urandom_range(80, 60);
    else if (pick < 15) len = 1;
    else len = $urandom_range(16, 2);
    pick = $urandom_range(2);
    amp = (pick == 0) ? 255 : (pick == 1) ? 4095 : 65535;
    for (int k = 0; k < len; k++) begin
      v = SAMPLE_BITS'($urandom_range(amp));
      if ($urandom_range(19) == 0) v = $urandom_range(1) ? '1 : '0;
      push_bin(v, k == len - 1);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_THRESHOLD:    thr = val;
      CFG_MATRIX_WIDTH: grid_cols = val[MW_W-1:0];
      CFG_LAST_SCALE:   scale_last = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_for_quiet();
    while (bins_taken != bins_pushed || onsets_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [THR_W-1:0]      thr_plan [PHASES];
    logic [CFG_DATA_W-1:0] cols_plan [PHASES];
    int target;
    thr_plan  = '{8'd128, 8'd0, 8'd255, 8'd26, 8'd0, 8'd255, 8'd13, 8'd64};
    cols_plan = '{8'd8, 8'd1, 8'd64, 8'd0, 8'd127, 8'd3, 8'd128, 8'd5};

    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 28;
    recv_idle_pct = 83;

    // reset settings; first frame rises by its full value, last bin scaled
    push_bin(16'hFFFF, 1'b0);
    push_bin(16'h0000, 1'b0);
    push_bin(16'd12345, 1'b0);
    push_bin(16'hFFFF, 1'b1);
    // same frame again: nothing rises
    push_bin(16'hFFFF, 1'b0);
    push_bin(16'h0000, 1'b0);
    push_bin(16'd12345, 1'b0);
    push_bin(16'hFFFF, 1'b1);
    // one-bin frame, falling
    push_bin(16'd40000, 1'b1);
    // equal rises on bins 1 and 2: bin 1 should win
    push_bin(16'd40000, 1'b0);
    push_bin(16'd20000, 1'b0);
    push_bin(16'd32345, 1'b0);
    push_bin(16'h0000, 1'b1);
    wait_for_quiet();

    // width zero acts as one, scaling off, spare index ignored
    write_reg(CFG_THRESHOLD, 8'd255);
    write_reg(CFG_MATRIX_WIDTH, 8'd0);
    write_reg(CFG_LAST_SCALE, 8'd0);
    write_reg(CFG_SPARE, 8'hFF);
    push_bin(16'hFFFF, 1'b0);
    push_bin(16'hFFFF, 1'b1);
    wait_for_quiet();
    write_reg(CFG_THRESHOLD, 8'd0);
    push_bin(16'hFFFF, 1'b0);
    push_bin(16'h8000, 1'b0);
    push_bin(16'h7FFF, 1'b1);
    wait_for_quiet();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 3) begin
        send_idle_pct = 83;
        recv_idle_pct = 28;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(CFG_THRESHOLD, (p == 7) ? THR_W'($urandom_range(255)) : thr_plan[p]);
      write_reg(CFG_MATRIX_WIDTH, cols_plan[p]);
      write_reg(CFG_LAST_SCALE, CFG_DATA_W'(p % 2));
      if (p == 4) write_reg(CFG_SPARE, 8'h00);
      target = bins_pushed + PHASE_BINS;
      while (bins_pushed < target) queue_frame();
      wait_for_quiet();
    end

    if (bad_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
